// File: rtl/pink_noise_burst_shaper_defines.svh
// Assertion macros for the pink noise burst shaper.
// Included by the RTL files that carry concurrent assertions; relies on clk and rst in scope.
`ifndef PINK_NOISE_BURST_SHAPER_DEFINES_SVH
`define PINK_NOISE_BURST_SHAPER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising edge and masked during reset.
`define PNBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pnbs: assertion failed");
// Next-cycle implication, sampled on the rising edge and masked during reset.
`define PNBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pnbs: assertion failed");
`else
`define PNBS_ASSERT_IMP(label, ante, cons)
`define PNBS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/pnbs_pkg.sv
// Shared types, constants and coefficient functions for the pink noise burst shaper.
// No dependencies; used by every module of the block.
package pnbs_pkg;

  localparam int FRAC_BITS_DEF   = 17;
  localparam int INDEX_WIDTH_DEF = 20;
  localparam int CFG_W           = 20;
  localparam int SAMPLE_W        = 16;

  localparam logic [CFG_W-1:0] BURST_LENGTH_RST = 20'd141120;

  // Decimal mantissas of the fixed coefficients, scaled by ten million.
  localparam longint unsigned M_DIRECT = 64'd5362000;
  localparam longint unsigned M_DELAY  = 64'd1159260;
  localparam longint unsigned M_SCALE  = 64'd1600000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POLE,
    ST_GAIN,
    ST_SUM,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_SCALE,
    ST_EMUL,
    ST_EDIV,
    ST_EWAIT,
    ST_SAT,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MOP_POLE,
    MOP_GAIN,
    MOP_DIRECT,
    MOP_DELAY,
    MOP_SCALE,
    MOP_ENV,
    MOP_OUT
  } mop_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Rounds a mantissa (scaled by ten million) to nearest at the given fraction width.
  function automatic longint qc(input longint unsigned m, input int frac);
    longint unsigned r;
    r = ((m << frac) + 64'd5000000) / 64'd10000000;
    return longint'(r);
  endfunction

  function automatic longint pole_coef(input logic [2:0] k, input int frac);
    longint c;
    unique case (k)
      3'd0:    c = qc(64'd9988600, frac);
      3'd1:    c = qc(64'd9933200, frac);
      3'd2:    c = qc(64'd9690000, frac);
      3'd3:    c = qc(64'd8665000, frac);
      3'd4:    c = qc(64'd5500000, frac);
      3'd5:    c = -qc(64'd7616000, frac);
      default: c = 0;
    endcase
    return c;
  endfunction

  function automatic longint gain_coef(input logic [2:0] k, input int frac);
    longint c;
    unique case (k)
      3'd0:    c = qc(64'd555179, frac);
      3'd1:    c = qc(64'd750759, frac);
      3'd2:    c = qc(64'd1538520, frac);
      3'd3:    c = qc(64'd3104856, frac);
      3'd4:    c = qc(64'd5329522, frac);
      3'd5:    c = -qc(64'd168980, frac);
      default: c = 0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/pnbs_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pnbs_pkg for its default operand widths.
module pnbs_mul #(
  parameter int A_W = pnbs_pkg::INDEX_WIDTH_DEF + 6,
  parameter int B_W = pnbs_pkg::FRAC_BITS_DEF + 13
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] prod
);

  // The product holds while the unit is not issued, so a result can wait for its consumer.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// File: rtl/pnbs_div.sv
// Restoring divider, one quotient bit per cycle, for the burst envelope.
// Depends on pnbs_pkg for the status struct and default widths.
`include "pink_noise_burst_shaper_defines.svh"
module pnbs_div #(
  parameter int Q_W = pnbs_pkg::FRAC_BITS_DEF + 12,
  parameter int D_W = pnbs_pkg::INDEX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [D_W-1:0]        rem_init,
  input  logic [Q_W-1:0]        dvd_init,
  input  logic [D_W-1:0]        den,
  output pnbs_pkg::div_stat_t   stat,
  output logic [Q_W-1:0]        quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   rem_next;
  logic [Q_W-1:0]   dvd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D_W:0]     trial;
  logic             ge;

  // The caller guarantees rem_init < den, so the quotient fits in Q_W bits.
  always_comb begin
    trial    = {rem, dvd[Q_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? D_W'(trial - {1'b0, den}) : D_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in at the bottom as the dividend bits leave at the top.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dvd <= dvd_init;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[Q_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quo       = dvd;

  `PNBS_ASSERT_NXT(a_div_start_busy, start, busy)
  `PNBS_ASSERT_IMP(a_div_done_idle, done, !busy)

endmodule

// File: rtl/pink_noise_burst_shaper.sv
// Pink noise burst shaper: one white noise word in, one shaped pink noise word out.
// Each word runs through the six filter sections and the direct, delayed and scale terms,
// and in the fade-in and fade-out regions also the envelope division, which runs one
// quotient bit per cycle. The single shared multiplier is issued twice per filter section
// and four times more per word (five in the fades). A new word is accepted while the
// previous result still waits at the output. The user must write burst_length only while
// the block is idle; the block itself does not enforce it.
// Depends on pnbs_pkg, pnbs_mul, pnbs_div and the assertion macro header.
`include "pink_noise_burst_shaper_defines.svh"
module pink_noise_burst_shaper #(
  parameter int FRAC_BITS   = pnbs_pkg::FRAC_BITS_DEF,
  parameter int INDEX_WIDTH = pnbs_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pnbs_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pnbs_pkg::SAMPLE_W-1:0] white_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pnbs_pkg::SAMPLE_W-1:0] pink_sample,
  output logic                                burst_last
);

  localparam int SW     = pnbs_pkg::SAMPLE_W;
  localparam int ACC_W  = FRAC_BITS + 10;
  localparam int PINK_W = FRAC_BITS + 13;
  localparam int MAG_W  = PINK_W - 1;
  localparam int COEF_W = FRAC_BITS + 2;
  localparam int FAC_W  = INDEX_WIDTH + 5;
  localparam int MA_T   = (COEF_W > FAC_W + 1) ? COEF_W : FAC_W + 1;
  localparam int MA_W   = (MA_T > SW) ? MA_T : SW;
  localparam int MB_W   = PINK_W;
  localparam int P_W    = MA_W + MB_W;

  localparam logic [INDEX_WIDTH-1:0] LEN_MAX = '1;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W+1:0] ACC_MAX_X = (ACC_W+2)'(ACC_MAX);
  localparam logic signed [ACC_W+1:0] ACC_MIN_X = (ACC_W+2)'(ACC_MIN);
  localparam logic signed [COEF_W-1:0] ONE_Q = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [COEF_W-1:0] NEG_ONE_Q = {2'b11, {FRAC_BITS{1'b0}}};
  localparam logic signed [PINK_W-1:0] ONE_X = PINK_W'(ONE_Q);
  localparam logic signed [PINK_W-1:0] NEG_ONE_X = PINK_W'(NEG_ONE_Q);
  localparam logic signed [P_W-1:0] HALF_F = {{(P_W-FRAC_BITS){1'b0}}, 1'b1,
                                              {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [P_W-1:0] HALF_15 = {{(P_W-15){1'b0}}, 1'b1, {14{1'b0}}};
  localparam logic signed [P_W-1:0] TRUNC_F = {{(P_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [P_W-1:0] ZERO_P = '0;
  localparam logic signed [SW-1:0] C_OUT = 16'sd32767;
  localparam logic signed [SW-1:0] MIN_SAMPLE = 16'sh8000;
  localparam logic signed [COEF_W-1:0] C_DIRECT =
    COEF_W'(pnbs_pkg::qc(pnbs_pkg::M_DIRECT, FRAC_BITS));
  localparam logic signed [COEF_W-1:0] C_DELAY =
    COEF_W'(pnbs_pkg::qc(pnbs_pkg::M_DELAY, FRAC_BITS));
  localparam logic signed [COEF_W-1:0] C_SCALE =
    COEF_W'(pnbs_pkg::qc(pnbs_pkg::M_SCALE, FRAC_BITS));

  pnbs_pkg::state_t state;
  pnbs_pkg::state_t state_next;
  pnbs_pkg::mop_t   mop;
  pnbs_pkg::div_stat_t div_stat;

  logic [pnbs_pkg::CFG_W-1:0] burst_length;
  logic [INDEX_WIDTH-1:0]     sample_index;
  logic [INDEX_WIDTH-1:0]     len_r;
  logic [INDEX_WIDTH-1:0]     idx_r;
  logic                       last_r;
  logic                       rise_r;
  logic                       fall_r;
  logic [FAC_W-1:0]           factor_r;
  logic signed [SW-1:0]       w_r;
  logic signed [ACC_W-1:0]    acc [7];
  logic [2:0]                 k;
  logic signed [ACC_W:0]      t1;
  logic signed [PINK_W-1:0]   pink;
  logic signed [PINK_W-1:0]   s_r;

  logic                       in_fire;
  logic                       fin_fire;
  logic                       mul_en;
  logic                       div_start;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [P_W-1:0]      prod;
  logic [MAG_W-1:0]           div_q;

  logic                       cfg_big;
  logic [INDEX_WIDTH-1:0]     len_cl;
  logic [INDEX_WIDTH-1:0]     len_eff;
  logic [INDEX_WIDTH-1:0]     len_m1;
  logic                       last_now;
  logic [INDEX_WIDTH-1:0]     idx_eff;
  logic [FAC_W-1:0]           idx20;
  logic [FAC_W-1:0]           len19;
  logic [FAC_W-1:0]           tail;
  logic [FAC_W-1:0]           tail20;
  logic                       rise_c;
  logic                       fall_c;
  logic signed [COEF_W-1:0]   pole_k;
  logic signed [COEF_W-1:0]   gain_k;
  logic signed [P_W-1:0]      prod_rf;
  logic signed [P_W-1:0]      prod_r15;
  logic signed [P_W-1:0]      prod_tz;
  logic signed [ACC_W+1:0]    sec_sum;
  logic signed [ACC_W-1:0]    sec_sat;
  logic                       s_neg;
  logic signed [PINK_W-1:0]   s_abs;
  logic [MAG_W-1:0]           s_mag;
  logic signed [PINK_W-1:0]   q_ext;
  logic signed [COEF_W-1:0]   s_sat;

  // Effective length and index for the word about to be accepted.
  always_comb begin
    cfg_big  = |(burst_length >> INDEX_WIDTH);
    len_cl   = cfg_big ? LEN_MAX : INDEX_WIDTH'(burst_length);
    len_eff  = (len_cl == '0) ? INDEX_WIDTH'(1) : len_cl;
    len_m1   = len_eff - INDEX_WIDTH'(1);
    last_now = sample_index >= len_m1;
    idx_eff  = last_now ? len_m1 : sample_index;
  end

  // Envelope region and ramp factor, multiplications by 20 and 19 done as shifts and adds.
  always_comb begin
    idx20  = (FAC_W'(idx_r) << 4) + (FAC_W'(idx_r) << 2);
    len19  = (FAC_W'(len_r) << 4) + (FAC_W'(len_r) << 1) + FAC_W'(len_r);
    tail   = FAC_W'(len_r - idx_r);
    tail20 = (tail << 4) + (tail << 2);
    rise_c = idx20 < FAC_W'(len_r);
    fall_c = idx20 > len19;
  end

  always_comb begin
    pole_k = COEF_W'(pnbs_pkg::pole_coef(k, FRAC_BITS));
    gain_k = COEF_W'(pnbs_pkg::gain_coef(k, FRAC_BITS));
  end

  // Rounding half up is an add before the arithmetic shift; truncation toward zero
  // biases negative products by one less than the divisor.
  always_comb begin
    prod_rf  = (prod + HALF_F) >>> FRAC_BITS;
    prod_r15 = (prod + HALF_15) >>> 15;
    prod_tz  = (prod + (prod[P_W-1] ? TRUNC_F : ZERO_P)) >>> FRAC_BITS;
  end

  always_comb begin
    sec_sum = (ACC_W+2)'(t1) + (ACC_W+2)'(prod_r15);
    if (sec_sum > ACC_MAX_X) begin
      sec_sat = ACC_MAX;
    end else if (sec_sum < ACC_MIN_X) begin
      sec_sat = ACC_MIN;
    end else begin
      sec_sat = ACC_W'(sec_sum);
    end
  end

  always_comb begin
    s_neg = s_r[PINK_W-1];
    s_abs = s_neg ? -s_r : s_r;
    s_mag = s_abs[MAG_W-1:0];
    q_ext = {1'b0, div_q};
    if (s_r > ONE_X) begin
      s_sat = ONE_Q;
    end else if (s_r < NEG_ONE_X) begin
      s_sat = NEG_ONE_Q;
    end else begin
      s_sat = COEF_W'(s_r);
    end
  end

  always_comb begin
    unique case (mop)
      pnbs_pkg::MOP_POLE: begin
        mul_a = MA_W'(pole_k);
        mul_b = MB_W'(acc[k]);
      end
      pnbs_pkg::MOP_GAIN: begin
        mul_a = MA_W'(gain_k);
        mul_b = MB_W'(w_r);
      end
      pnbs_pkg::MOP_DIRECT: begin
        mul_a = MA_W'(C_DIRECT);
        mul_b = MB_W'(w_r);
      end
      pnbs_pkg::MOP_DELAY: begin
        mul_a = MA_W'(C_DELAY);
        mul_b = MB_W'(w_r);
      end
      pnbs_pkg::MOP_SCALE: begin
        mul_a = MA_W'(C_SCALE);
        mul_b = MB_W'(pink);
      end
      pnbs_pkg::MOP_ENV: begin
        mul_a = MA_W'({1'b0, factor_r});
        mul_b = MB_W'({1'b0, s_mag});
      end
      pnbs_pkg::MOP_OUT: begin
        mul_a = MA_W'(C_OUT);
        mul_b = MB_W'(s_sat);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pnbs_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // The envelope product is below len * 2^MAG_W, so its upper bits start the remainder.
  pnbs_div #(
    .Q_W (MAG_W),
    .D_W (INDEX_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (prod[MAG_W +: INDEX_WIDTH]),
    .dvd_init (prod[MAG_W-1:0]),
    .den      (len_r),
    .stat     (div_stat),
    .quo      (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      pnbs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pnbs_pkg::ST_POLE;
        end
      end
      pnbs_pkg::ST_POLE:  state_next = pnbs_pkg::ST_GAIN;
      pnbs_pkg::ST_GAIN:  state_next = pnbs_pkg::ST_SUM;
      pnbs_pkg::ST_SUM: begin
        state_next = (k == 3'd5) ? pnbs_pkg::ST_D1 : pnbs_pkg::ST_POLE;
      end
      pnbs_pkg::ST_D1:    state_next = pnbs_pkg::ST_D2;
      pnbs_pkg::ST_D2:    state_next = pnbs_pkg::ST_D3;
      pnbs_pkg::ST_D3:    state_next = pnbs_pkg::ST_SCALE;
      pnbs_pkg::ST_SCALE: begin
        state_next = (rise_r || fall_r) ? pnbs_pkg::ST_EMUL : pnbs_pkg::ST_SAT;
      end
      pnbs_pkg::ST_EMUL:  state_next = pnbs_pkg::ST_EDIV;
      pnbs_pkg::ST_EDIV:  state_next = pnbs_pkg::ST_EWAIT;
      pnbs_pkg::ST_EWAIT: begin
        if (div_stat.done) begin
          state_next = pnbs_pkg::ST_SAT;
        end
      end
      pnbs_pkg::ST_SAT:   state_next = pnbs_pkg::ST_FIN;
      pnbs_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = pnbs_pkg::ST_IDLE;
        end
      end
      default:            state_next = pnbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    mop       = pnbs_pkg::MOP_POLE;
    div_start = 1'b0;
    unique case (state)
      pnbs_pkg::ST_IDLE:  in_ready = 1'b1;
      pnbs_pkg::ST_POLE: begin
        mul_en = 1'b1;
        mop    = pnbs_pkg::MOP_POLE;
      end
      pnbs_pkg::ST_GAIN: begin
        mul_en = 1'b1;
        mop    = pnbs_pkg::MOP_GAIN;
      end
      pnbs_pkg::ST_D1: begin
        mul_en = 1'b1;
        mop    = pnbs_pkg::MOP_DIRECT;
      end
      pnbs_pkg::ST_D2: begin
        mul_en = 1'b1;
        mop    = pnbs_pkg::MOP_DELAY;
      end
      pnbs_pkg::ST_D3: begin
        mul_en = 1'b1;
        mop    = pnbs_pkg::MOP_SCALE;
      end
      pnbs_pkg::ST_EMUL: begin
        mul_en = 1'b1;
        mop    = pnbs_pkg::MOP_ENV;
      end
      pnbs_pkg::ST_EDIV:  div_start = 1'b1;
      pnbs_pkg::ST_SAT: begin
        mul_en = 1'b1;
        mop    = pnbs_pkg::MOP_OUT;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_fire  = in_valid && in_ready;
  assign fin_fire = (state == pnbs_pkg::ST_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pnbs_pkg::ST_IDLE;
      burst_length <= pnbs_pkg::BURST_LENGTH_RST;
      sample_index <= '0;
      out_valid    <= 1'b0;
      k            <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        burst_length <= cfg_data;
      end
      if (in_fire) begin
        k <= '0;
      end else if (state == pnbs_pkg::ST_SUM) begin
        k <= k + 3'd1;
      end
      if (fin_fire) begin
        out_valid    <= 1'b1;
        sample_index <= last_r ? '0 : sample_index + INDEX_WIDTH'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Filter state: the six sections and the one-word delayed term, cleared at a burst end.
  always_ff @(posedge clk) begin
    if (rst || (fin_fire && last_r)) begin
      for (int i = 0; i < 7; i++) begin
        acc[i] <= '0;
      end
    end else if (state == pnbs_pkg::ST_SUM) begin
      acc[k] <= sec_sat;
    end else if (state == pnbs_pkg::ST_D3) begin
      // The delayed term is well below full scale, so it never saturates.
      acc[6] <= ACC_W'(prod_r15);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r    <= white_sample;
      pink   <= '0;
      len_r  <= len_eff;
      idx_r  <= idx_eff;
      last_r <= last_now;
    end
    if (state == pnbs_pkg::ST_GAIN) begin
      t1 <= (ACC_W+1)'(prod_rf);
    end
    if (state == pnbs_pkg::ST_SUM) begin
      pink <= pink + PINK_W'(sec_sat);
    end
    if (state == pnbs_pkg::ST_D1) begin
      rise_r   <= rise_c;
      fall_r   <= fall_c;
      factor_r <= rise_c ? idx20 : tail20;
    end
    if (state == pnbs_pkg::ST_D2) begin
      pink <= pink + PINK_W'(acc[6]) + PINK_W'(prod_r15);
    end
    if (state == pnbs_pkg::ST_SCALE) begin
      s_r <= PINK_W'(prod_rf);
    end
    if ((state == pnbs_pkg::ST_EWAIT) && div_stat.done) begin
      s_r <= s_neg ? -q_ext : q_ext;
    end
    if (fin_fire) begin
      pink_sample <= SW'(prod_tz);
      burst_last  <= last_r;
    end
  end

  `PNBS_ASSERT_NXT(a_last_restarts, fin_fire, burst_last == (sample_index == '0))
  `PNBS_ASSERT_NXT(a_sample_range, fin_fire, pink_sample != MIN_SAMPLE)
  `PNBS_ASSERT_IMP(a_idle_div_quiet, in_ready, !div_stat.busy)
  `PNBS_ASSERT_NXT(a_last_clears, fin_fire && last_r, acc[0] == '0 && acc[6] == '0)

endmodule

// File: bench/pink_noise_burst_shaper_tb.sv
// Self-checking bench for pink_noise_burst_shaper: a short table of opening words, then
// random phases over many burst lengths; results come from the table or a local predictor.
// Depends on pnbs_pkg and the pink_noise_burst_shaper RTL only.
`timescale 1ns / 100ps
module pink_noise_burst_shaper_tb;

  localparam int SAMPLE_W       = pnbs_pkg::SAMPLE_W;
  localparam int CFG_W          = pnbs_pkg::CFG_W;
  localparam int RANDOM_WORDS   = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_PHASE     = 4;
  localparam int FRAC           = 17;
  localparam longint ACC_TOP    = (64'sd1 <<< (FRAC + 9)) - 1;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam longint UNITY      = 64'sd1 <<< FRAC;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pink;
    logic                       is_last;
  } shaped_t;

  typedef struct packed {
    logic                       set_len;
    logic [CFG_W-1:0]           len;
    logic signed [SAMPLE_W-1:0] white;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] t_pink;
    logic                       t_last;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_W-1:0]           cfg_data = pnbs_pkg::BURST_LENGTH_RST;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] white_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] pink_sample;
  logic                       burst_last;

  // Predictor state: coefficients, section accumulators, index and length.
  longint           pole_q[6];
  longint           gain_q[6];
  longint           direct_q, delay_q, scale_q;
  longint           sec_acc[7];
  logic [CFG_W-1:0] burst_len_cfg;
  logic [CFG_W-1:0] sample_idx;

  shaped_t shaped_words_due[$];
  shaped_t seen_due;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  bit      rx_calm = 1'b0;
  bit      rx_hold_req = 1'b0;

  // The opening word of any burst is faded to zero, and a length of zero or one
  // makes every word the last, so those rows carry their results directly.
  stim_row_t opening_rows [21] = '{
    '{1'b0, 20'd0, 16'sd32767, 1'b1, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sd32767, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sh8000, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sh8000, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, -16'sd1, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sd1, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sd21845, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, -16'sd21846, 1'b0, 16'sd0, 1'b0},
    '{1'b1, 20'd0, 16'sd32767, 1'b1, 16'sd0, 1'b1},
    '{1'b0, 20'd0, 16'sh8000, 1'b1, 16'sd0, 1'b1},
    '{1'b1, 20'd1, 16'sd12345, 1'b1, 16'sd0, 1'b1},
    '{1'b1, 20'd2, 16'sd32767, 1'b1, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sd32767, 1'b0, 16'sd0, 1'b0},
    '{1'b1, 20'd3, 16'sh8000, 1'b1, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sh8000, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sh8000, 1'b0, 16'sd0, 1'b0},
    '{1'b1, 20'd20, 16'sd32767, 1'b1, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sd32767, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sh8000, 1'b0, 16'sd0, 1'b0},
    '{1'b0, 20'd0, 16'sd100, 1'b0, 16'sd0, 1'b0}
  };

  logic [CFG_W-1:0] phase_lengths [10] = '{
    20'd20, 20'd1048575, 20'd0, 20'd1, 20'd21, 20'd19, 20'd2, 20'd40, 20'd141120, 20'd3
  };

  pink_noise_burst_shaper uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .white_sample (white_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pink_sample  (pink_sample),
    .burst_last   (burst_last)
  );

  always #1 clk = ~clk;

  function automatic longint to_q17(input longint m);
    return ((m <<< FRAC) + 64'sd5000000) / 64'sd10000000;
  endfunction

  function automatic longint clamp_acc(input longint v);
    if (v > ACC_TOP) return ACC_TOP;
    if (v < ACC_BOTTOM) return ACC_BOTTOM;
    return v;
  endfunction

  // Advances the filter and burst state by one white word and returns the shaped word.
  function automatic shaped_t shape_next_word(input logic signed [SAMPLE_W-1:0] white);
    longint  w, pink, s, len, idx;
    shaped_t res;
    w = longint'(white);
    pink = 0;
    for (int k = 0; k < 6; k++) begin
      sec_acc[k] = clamp_acc(((pole_q[k] * sec_acc[k] + 65536) >>> FRAC) +
                             ((gain_q[k] * w + 16384) >>> 15));
      pink += sec_acc[k];
    end
    pink += sec_acc[6] + ((direct_q * w + 16384) >>> 15);
    sec_acc[6] = clamp_acc((delay_q * w + 16384) >>> 15);

    len = longint'(burst_len_cfg);
    if (len == 0) len = 1;
    idx = longint'(sample_idx);
    if (idx > len - 1) idx = len - 1;

    s = (pink * scale_q + 65536) >>> FRAC;
    if (idx * 20 < len)
      s = (s * idx * 20) / len;
    else if (idx * 20 > len * 19)
      s = (s * (len - idx) * 20) / len;
    if (s > UNITY) s = UNITY;
    if (s < -UNITY) s = -UNITY;
    s = (s * 32767) / UNITY;

    res.pink = s[SAMPLE_W-1:0];
    res.is_last = (longint'(sample_idx) >= len - 1);
    if (res.is_last) begin
      sample_idx = '0;
      for (int k = 0; k < 7; k++) sec_acc[k] = 0;
    end else begin
      sample_idx = sample_idx + CFG_W'(1);
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Bias 1 and 2 push the filter hard one way so that the output saturates mid-burst.
  function automatic logic signed [SAMPLE_W-1:0] pick_white(input int bias);
    int n;
    n = $urandom_range(0, 9);
    if (n == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'sd32767;
        1: return 16'sh8000;
        2: return -16'sd32767;
        default: return 16'sd0;
      endcase
    end
    if (bias == 1) return SAMPLE_W'($urandom_range(8192, 32767));
    if (bias == 2) begin
      n = $urandom_range(8192, 32768);
      return SAMPLE_W'(-n);
    end
    return SAMPLE_W'($urandom);
  endfunction

  task automatic offer_word(input logic signed [SAMPLE_W-1:0] white);
    white_sample <= white;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    shaped_words_due.push_back(shape_next_word(white));
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Lengths change only once every outstanding word has come back.
  task automatic write_burst_length(input logic [CFG_W-1:0] len);
    if (in_valid) in_valid <= 1'b0;
    while (shaped_words_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    burst_len_cfg = len;
  endtask

  initial begin
    int               phase;
    int               words_sent;
    int               count;
    int               bias;
    bit               sender_calm;
    logic [CFG_W-1:0] len;

    pole_q[0] = to_q17(9988600);
    pole_q[1] = to_q17(9933200);
    pole_q[2] = to_q17(9690000);
    pole_q[3] = to_q17(8665000);
    pole_q[4] = to_q17(5500000);
    pole_q[5] = -to_q17(7616000);
    gain_q[0] = to_q17(555179);
    gain_q[1] = to_q17(750759);
    gain_q[2] = to_q17(1538520);
    gain_q[3] = to_q17(3104856);
    gain_q[4] = to_q17(5329522);
    gain_q[5] = -to_q17(168980);
    direct_q = to_q17(5362000);
    delay_q = to_q17(1159260);
    scale_q = to_q17(1600000);
    for (int k = 0; k < 7; k++) sec_acc[k] = 0;
    sample_idx = '0;
    burst_len_cfg = pnbs_pkg::BURST_LENGTH_RST;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      if (opening_rows[i].set_len) write_burst_length(opening_rows[i].len);
      offer_word(opening_rows[i].white);
      if (opening_rows[i].typed)
        shaped_words_due[shaped_words_due.size() - 1] =
          {opening_rows[i].t_pink, opening_rows[i].t_last};
      idle_sender(pick_gap());
    end

    words_sent = 0;
    for (phase = 0; words_sent < RANDOM_WORDS; phase++) begin
      len = (phase < 10) ? phase_lengths[phase] : 20'($urandom_range(3, 300));
      write_burst_length(len);
      sender_calm = (phase % 4 == 3);
      rx_calm = sender_calm;
      // The receiver stalls for a long while here and the sender keeps pushing words.
      if (phase == HOLD_PHASE) rx_hold_req = 1'b1;
      bias = $urandom_range(0, 2);
      count = $urandom_range(25, 70);
      repeat (count) begin
        offer_word(pick_white(bias));
        words_sent++;
        if (!sender_calm && phase != HOLD_PHASE) idle_sender(pick_gap());
      end
    end

    if (in_valid) in_valid <= 1'b0;
    while (shaped_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (shaped_words_due.size() == 0) begin
        $display("%0t: unexpected word, pink_sample %0d burst_last %b",
                 $time, pink_sample, burst_last);
        mismatch_count++;
      end else begin
        seen_due = shaped_words_due.pop_front();
        if (pink_sample !== seen_due.pink) begin
          $display("%0t: pink_sample expected %0d, got %0d",
                   $time, seen_due.pink, pink_sample);
          mismatch_count++;
        end
        if (burst_last !== seen_due.is_last) begin
          $display("%0t: burst_last expected %b, got %b",
                   $time, seen_due.is_last, burst_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

// File: files.f
+incdir+rtl
rtl/pnbs_pkg.sv
rtl/pnbs_mul.sv
rtl/pnbs_div.sv
rtl/pink_noise_burst_shaper.sv
bench/pink_noise_burst_shaper_tb.sv
